/* rtl/heating_relay_supervisor_top_defines.svh */
// ----------------------------------------------------------------------------
// heating relay supervisor assertion macros
// shared property forms for the relay supervisor checks, sampled on clk
// and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef HEATING_RELAY_SUPERVISOR_TOP_DEFINES_SVH
`define HEATING_RELAY_SUPERVISOR_TOP_DEFINES_SVH

// same-cycle implication
`define HRS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HRS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/hrs_pkg.sv */
// ----------------------------------------------------------------------------
// hrs_pkg
// types and constants shared by the heating relay supervisor modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hrs_pkg;

	localparam logic [15:0] STARTUP_MS = 16'd3000;
	localparam logic [15:0] MINUTE_MS  = 16'd60000;
	localparam logic signed [11:0] LIMIT_HYST = 12'sd30;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 10;
	localparam logic [CFG_IDX_W-1:0] REG_SENSOR_MODE_ALL     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR_LIMIT_TEMP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_CONTROL_ON     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RUN_MINUTES         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REST_MINUTES        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RELAY_OUT_TYPE      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_TEMP_PROTECT_ON = 3'd6;

	// run status codes
	localparam logic [1:0] RS_NORMAL    = 2'd0;
	localparam logic [1:0] RS_POWER_OFF = 2'd1;
	localparam logic [1:0] RS_HIGH_SET  = 2'd2;
	localparam logic [1:0] RS_TIMING    = 2'd3;

	// relay output types
	localparam logic [1:0] OUT_BOTH      = 2'd0;
	localparam logic [1:0] OUT_MAIN_ONLY = 2'd1;
	localparam logic [1:0] OUT_INVERTED  = 2'd2;
	localparam logic [1:0] OUT_INV_OFF   = 2'd3;

	// duty phase codes as shown on the result
	localparam logic [1:0] DUTY_CODE_IDLE = 2'd0;
	localparam logic [1:0] DUTY_CODE_RUN  = 2'd1;
	localparam logic [1:0] DUTY_CODE_REST = 2'd2;

	typedef enum logic [2:0] {
		SU_INIT  = 3'b001,
		SU_DELAY = 3'b010,
		SU_RUN   = 3'b100
	} startup_t;

	typedef enum logic [2:0] {
		DUTY_IDLE = 3'b001,
		DUTY_RUN  = 3'b010,
		DUTY_REST = 3'b100
	} duty_t;

	typedef struct packed {
		logic       sensor_mode_all;
		logic [9:0] floor_limit_temp;
		logic       time_control_on;
		logic [7:0] run_minutes;
		logic [7:0] rest_minutes;
		logic [1:0] relay_out_type;
		logic       low_temp_protect_on;
	} hrs_cfg_t;

	typedef struct packed {
		logic [15:0]        now_ms;
		logic               floor_demand;
		logic [1:0]         run_status;
		logic               timing_display_on;
		logic               system_error;
		logic signed [10:0] floor_temp;
	} hrs_item_t;

	typedef struct packed {
		startup_t    startup_phase;
		logic [15:0] startup_mark;
		logic        limit_flag;
		duty_t       duty_phase;
		logic [7:0]  minute_count;
		logic [15:0] minute_mark;
		logic        timer_indicator;
		logic        main_out;
		logic        assist_out;
	} hrs_state_t;

	typedef struct packed {
		logic       main_relay_on;
		logic       assist_relay_on;
		logic       heat_request;
		logic       over_limit;
		logic [1:0] timer_phase;
		logic       timer_shown;
	} hrs_result_t;

endpackage

/* rtl/heating_relay_supervisor_top.sv */
// ----------------------------------------------------------------------------
// heating_relay_supervisor_top
// relay request supervisor for a floor heating controller: start-up delay,
// floor over-limit hysteresis, run/rest duty timer, relay output mapping
// ----------------------------------------------------------------------------
//
// channel   direction  handshake               payload
// in        input      in_valid / in_stall     now_ms .. floor_temp, one scan
// out       output     out_valid / out_stall   main_relay_on .. timer_shown
// cfg       input      cfg_we (no handshake)   cfg_index, cfg_data
//
// one scan per cycle sustained while out_stall stays low; a scan is accepted
// into the input register, evaluated combinationally from it and registered
// into the result register, which drives out_valid, once that register can load
// the supervisor state updates as the scan moves into the result register,
// which is the only loop
// arst_n clears the valid flags, the supervisor state and the cfg registers
// out_stall holds the result register; the input register still takes one
// more scan if it is empty, then in_stall rises
//
`timescale 1ns / 1ps

`include "heating_relay_supervisor_top_defines.svh"

module heating_relay_supervisor_top (
	input  logic                           clk,
	input  logic                           arst_n,

	// configuration write port
	input  logic                           cfg_we,
	input  logic [hrs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hrs_pkg::CFG_DATA_W-1:0] cfg_data,

	// scan input channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [15:0]                    now_ms,
	input  logic                           floor_demand,
	input  logic [1:0]                     run_status,
	input  logic                           timing_display_on,
	input  logic                           system_error,
	input  logic signed [10:0]             floor_temp,

	// result channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           main_relay_on,
	output logic                           assist_relay_on,
	output logic                           heat_request,
	output logic                           over_limit,
	output logic [1:0]                     timer_phase,
	output logic                           timer_shown
);
	import hrs_pkg::*;

	hrs_cfg_t    cfg;
	hrs_item_t   item_s1;
	logic        valid_s1;
	hrs_state_t  st_q;
	hrs_state_t  st_next;
	hrs_result_t res;
	hrs_result_t res_q;
	logic        out_valid_q;
	logic        advance;
	logic        in_take;

	// configuration registers
	hrs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// result register can load when empty or when its transaction completes
	assign advance  = !out_valid_q || !out_stall;
	// input register refuses only while it holds a scan that cannot move on
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.now_ms            <= now_ms;
			item_s1.floor_demand      <= floor_demand;
			item_s1.run_status        <= run_status;
			item_s1.timing_display_on <= timing_display_on;
			item_s1.system_error      <= system_error;
			item_s1.floor_temp        <= floor_temp;
		end
	end

	// scan evaluation
	hrs_step u_step (
		.st      (st_q),
		.cfg     (cfg),
		.item    (item_s1),
		.st_next (st_next),
		.res     (res)
	);

	// supervisor state commits together with the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.startup_phase   <= SU_INIT;
			st_q.startup_mark    <= 16'd0;
			st_q.limit_flag      <= 1'b0;
			st_q.duty_phase      <= DUTY_IDLE;
			st_q.minute_count    <= 8'd0;
			st_q.minute_mark     <= 16'd0;
			st_q.timer_indicator <= 1'b0;
			st_q.main_out        <= 1'b0;
			st_q.assist_out      <= 1'b0;
		end else if (valid_s1 && advance) begin
			st_q <= st_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance)
			res_q <= res;
	end

	assign out_valid       = out_valid_q;
	assign main_relay_on   = res_q.main_relay_on;
	assign assist_relay_on = res_q.assist_relay_on;
	assign heat_request    = res_q.heat_request;
	assign over_limit      = res_q.over_limit;
	assign timer_phase     = res_q.timer_phase;
	assign timer_shown     = res_q.timer_shown;

	// checks
	`HRS_ASSERT_IMP(a_rest_no_heat, out_valid_q && (res_q.timer_phase == DUTY_CODE_REST), !res_q.heat_request, "heat requested during rest phase")
	`HRS_ASSERT_IMP(a_shown_match, out_valid_q, res_q.timer_shown == (res_q.timer_phase != DUTY_CODE_IDLE), "timer indicator disagrees with duty phase")
	`HRS_ASSERT_IMP(a_startup_no_heat, out_valid_q && (st_q.startup_phase != SU_RUN), !res_q.heat_request, "heat requested before start-up delay ended")
	`HRS_ASSERT_NXT(a_held_scan_kept, valid_s1 && !advance, valid_s1, "held scan dropped from input register")

endmodule

/* rtl/hrs_cfg.sv */
// ----------------------------------------------------------------------------
// hrs_cfg
// configuration register file with write-only indexed access
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hrs_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [hrs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [hrs_pkg::CFG_DATA_W-1:0]  cfg_data,
	output hrs_pkg::hrs_cfg_t               cfg
);
	import hrs_pkg::*;

	hrs_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sensor_mode_all     <= 1'b0;
			cfg_q.floor_limit_temp    <= 10'd350;
			cfg_q.time_control_on     <= 1'b0;
			cfg_q.run_minutes         <= 8'd30;
			cfg_q.rest_minutes        <= 8'd30;
			cfg_q.relay_out_type      <= OUT_BOTH;
			cfg_q.low_temp_protect_on <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SENSOR_MODE_ALL:     cfg_q.sensor_mode_all     <= cfg_data[0];
				REG_FLOOR_LIMIT_TEMP:    cfg_q.floor_limit_temp    <= cfg_data[9:0];
				REG_TIME_CONTROL_ON:     cfg_q.time_control_on     <= cfg_data[0];
				REG_RUN_MINUTES:         cfg_q.run_minutes         <= cfg_data[7:0];
				REG_REST_MINUTES:        cfg_q.rest_minutes        <= cfg_data[7:0];
				REG_RELAY_OUT_TYPE:      cfg_q.relay_out_type      <= cfg_data[1:0];
				REG_LOW_TEMP_PROTECT_ON: cfg_q.low_temp_protect_on <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/hrs_step.sv */
// ----------------------------------------------------------------------------
// hrs_step
// one scan of the supervisor: next state and result from state, config, item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hrs_step (
	input  hrs_pkg::hrs_state_t  st,
	input  hrs_pkg::hrs_cfg_t    cfg,
	input  hrs_pkg::hrs_item_t   item,
	output hrs_pkg::hrs_state_t  st_next,
	output hrs_pkg::hrs_result_t res
);
	import hrs_pkg::*;

	logic [15:0]        startup_elapsed;
	logic [15:0]        minute_elapsed;
	logic [7:0]         count_inc;
	logic [7:0]         phase_limit;
	logic signed [11:0] temp_ext;
	logic signed [11:0] limit_ext;
	logic signed [11:0] limit_low;
	logic               enable;
	logic               heat;

	assign startup_elapsed = item.now_ms - st.startup_mark;
	assign minute_elapsed  = item.now_ms - st.minute_mark;
	assign count_inc       = st.minute_count + 8'd1;
	assign phase_limit     = (st.duty_phase == DUTY_REST) ? cfg.rest_minutes : cfg.run_minutes;
	assign temp_ext        = {item.floor_temp[10], item.floor_temp};
	assign limit_ext       = signed'({2'b00, cfg.floor_limit_temp});
	assign limit_low       = limit_ext - LIMIT_HYST;

	always_comb begin
		unique case (item.run_status)
			RS_POWER_OFF, RS_HIGH_SET: enable = 1'b0;
			RS_TIMING:                 enable = !item.timing_display_on;
			default:                   enable = !item.system_error;
		endcase
	end

	always_comb begin
		st_next = st;
		heat    = 1'b0;

		priority if (st.startup_phase == SU_INIT) begin
			st_next.startup_mark  = item.now_ms;
			st_next.startup_phase = SU_DELAY;
		end else if (st.startup_phase == SU_DELAY) begin
			if (startup_elapsed > STARTUP_MS)
				st_next.startup_phase = SU_RUN;
		end else begin
			// demand and floor limit
			if (enable) begin
				heat = item.floor_demand;
				if (item.floor_demand && cfg.sensor_mode_all) begin
					if (item.system_error)
						st_next.limit_flag = 1'b0;
					else if (temp_ext >= limit_ext)
						st_next.limit_flag = 1'b1;
					else if (temp_ext <= limit_low)
						st_next.limit_flag = 1'b0;
					if (st_next.limit_flag)
						heat = 1'b0;
				end else begin
					st_next.limit_flag = 1'b0;
				end
			end else begin
				heat = (item.run_status == RS_POWER_OFF) && cfg.low_temp_protect_on &&
					!item.system_error && item.floor_demand;
			end

			// run/rest duty timer
			if (cfg.time_control_on && enable && heat) begin
				if (st.duty_phase == DUTY_IDLE) begin
					st_next.minute_count    = 8'd0;
					st_next.duty_phase      = DUTY_RUN;
					st_next.minute_mark     = item.now_ms;
					st_next.timer_indicator = 1'b1;
				end else if (minute_elapsed >= MINUTE_MS) begin
					st_next.minute_mark  = item.now_ms;
					st_next.minute_count = count_inc;
					if (count_inc >= phase_limit) begin
						st_next.minute_count = 8'd0;
						st_next.duty_phase   = (st.duty_phase == DUTY_REST) ? DUTY_RUN : DUTY_REST;
					end
				end
			end else begin
				st_next.minute_count    = 8'd0;
				st_next.duty_phase      = DUTY_IDLE;
				st_next.minute_mark     = item.now_ms;
				st_next.timer_indicator = 1'b0;
			end
			if (st_next.duty_phase == DUTY_REST)
				heat = 1'b0;

			// relay mapping
			unique case (cfg.relay_out_type)
				OUT_BOTH: begin
					st_next.main_out   = heat;
					st_next.assist_out = heat;
				end
				OUT_MAIN_ONLY: begin
					st_next.main_out   = heat;
					st_next.assist_out = !heat;
				end
				OUT_INVERTED: begin
					st_next.main_out   = !heat;
					st_next.assist_out = !heat;
				end
				OUT_INV_OFF: begin
					st_next.main_out   = !heat &&
						((item.run_status != RS_POWER_OFF) || cfg.low_temp_protect_on);
					st_next.assist_out = st_next.main_out;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		res.main_relay_on   = st_next.main_out;
		res.assist_relay_on = st_next.assist_out;
		res.heat_request    = heat;
		res.over_limit      = st_next.limit_flag;
		res.timer_shown     = st_next.timer_indicator;
		unique case (st_next.duty_phase)
			DUTY_RUN:  res.timer_phase = DUTY_CODE_RUN;
			DUTY_REST: res.timer_phase = DUTY_CODE_REST;
			default:   res.timer_phase = DUTY_CODE_IDLE;
		endcase
	end

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: heating relay supervisor testbench
// drives scans through the valid/stall input channel and checks every relay
// result against a cycle-free predictor of the supervisor kept in a scoreboard
// class; covers start-up delay, limit hysteresis, duty timer and all output
// types under random idling, two long result hold-offs and register changes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

	import hrs_pkg::*;

	localparam int WATCHDOG_CYCLES = 2000;
	localparam int PHASES          = 10;
	localparam int SCANS_PER_PHASE = 80;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [15:0]           now_ms;
	logic                  floor_demand;
	logic [1:0]            run_status;
	logic                  timing_display_on;
	logic                  system_error;
	logic signed [10:0]    floor_temp;
	logic                  out_valid;
	logic                  out_stall;
	logic                  main_relay_on;
	logic                  assist_relay_on;
	logic                  heat_request;
	logic                  over_limit;
	logic [1:0]            timer_phase;
	logic                  timer_shown;

	// no idling on either side while set
	bit                    steady;
	// running millisecond time of the scan sequence
	logic [15:0]           scan_clock;

	// ------------------------------------------------------------------------
	// scoreboard: own copy of supervisor state and registers, predicts the
	// relay result of each accepted scan and checks results in order
	// ------------------------------------------------------------------------
	class relay_checker;
		hrs_cfg_t    regs;
		startup_t    su_phase;
		logic [15:0] su_mark;
		logic        lim_flag;
		duty_t       duty;
		logic [7:0]  minutes;
		logic [15:0] minute_mark;
		logic        shown;
		logic        main_q;
		logic        assist_q;
		hrs_result_t due_relays[$];
		int          errors;

		function new();
			regs = '{sensor_mode_all: 1'b0, floor_limit_temp: 10'd350,
				time_control_on: 1'b0, run_minutes: 8'd30, rest_minutes: 8'd30,
				relay_out_type: OUT_BOTH, low_temp_protect_on: 1'b0};
			su_phase    = SU_INIT;
			su_mark     = '0;
			lim_flag    = 1'b0;
			duty        = DUTY_IDLE;
			minutes     = '0;
			minute_mark = '0;
			shown       = 1'b0;
			main_q      = 1'b0;
			assist_q    = 1'b0;
			errors      = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_SENSOR_MODE_ALL:     regs.sensor_mode_all     = val[0];
				REG_FLOOR_LIMIT_TEMP:    regs.floor_limit_temp    = val[9:0];
				REG_TIME_CONTROL_ON:     regs.time_control_on     = val[0];
				REG_RUN_MINUTES:         regs.run_minutes         = val[7:0];
				REG_REST_MINUTES:        regs.rest_minutes        = val[7:0];
				REG_RELAY_OUT_TYPE:      regs.relay_out_type      = val[1:0];
				REG_LOW_TEMP_PROTECT_ON: regs.low_temp_protect_on = val[0];
				default: ;
			endcase
		endfunction

		function int pending();
			return due_relays.size();
		endfunction

		// advance the supervisor by one scan and queue the relay result
		function void take_scan(hrs_item_t s);
			logic        heat;
			logic        enable;
			logic [15:0] elapsed;
			logic [7:0]  phase_len;
			int          temp;
			int          lim;
			hrs_result_t r;
			heat = 1'b0;
			case (su_phase)
				SU_INIT: begin
					su_mark  = s.now_ms;
					su_phase = SU_DELAY;
				end
				SU_DELAY: begin
					elapsed = s.now_ms - su_mark;
					if (elapsed > STARTUP_MS)
						su_phase = SU_RUN;
				end
				default: begin
					case (s.run_status)
						RS_POWER_OFF, RS_HIGH_SET: enable = 1'b0;
						RS_TIMING:                 enable = !s.timing_display_on;
						default:                   enable = !s.system_error;
					endcase

					if (enable) begin
						heat = s.floor_demand;
						if (heat && regs.sensor_mode_all) begin
							if (s.system_error) begin
								lim_flag = 1'b0;
							end else begin
								temp = int'($signed(s.floor_temp));
								lim  = int'(regs.floor_limit_temp);
								if (temp >= lim)
									lim_flag = 1'b1;
								else if (temp <= lim - int'(LIMIT_HYST))
									lim_flag = 1'b0;
							end
							if (lim_flag)
								heat = 1'b0;
						end else begin
							lim_flag = 1'b0;
						end
					end else begin
						heat = (s.run_status == RS_POWER_OFF && regs.low_temp_protect_on
							&& !s.system_error) ? s.floor_demand : 1'b0;
					end

					// run/rest duty timer, minute steps of 60 s
					if (regs.time_control_on && enable && heat) begin
						if (duty == DUTY_IDLE) begin
							minutes     = '0;
							duty        = DUTY_RUN;
							minute_mark = s.now_ms;
							shown       = 1'b1;
						end else begin
							elapsed = s.now_ms - minute_mark;
							if (elapsed >= MINUTE_MS) begin
								minute_mark = s.now_ms;
								minutes     = minutes + 8'd1;
								phase_len   = (duty == DUTY_REST) ? regs.rest_minutes
									: regs.run_minutes;
								if (minutes >= phase_len) begin
									minutes = '0;
									duty    = (duty == DUTY_REST) ? DUTY_RUN : DUTY_REST;
								end
							end
						end
					end else begin
						minutes     = '0;
						duty        = DUTY_IDLE;
						minute_mark = s.now_ms;
						shown       = 1'b0;
					end
					if (duty == DUTY_REST)
						heat = 1'b0;

					if (heat) begin
						case (regs.relay_out_type)
							OUT_BOTH:      {main_q, assist_q} = 2'b11;
							OUT_MAIN_ONLY: {main_q, assist_q} = 2'b10;
							default:       {main_q, assist_q} = 2'b00;
						endcase
					end else begin
						case (regs.relay_out_type)
							OUT_BOTH:      {main_q, assist_q} = 2'b00;
							OUT_MAIN_ONLY: {main_q, assist_q} = 2'b01;
							OUT_INVERTED:  {main_q, assist_q} = 2'b11;
							default: begin
								if (s.run_status != RS_POWER_OFF || regs.low_temp_protect_on)
									{main_q, assist_q} = 2'b11;
								else
									{main_q, assist_q} = 2'b00;
							end
						endcase
					end
				end
			endcase

			r.main_relay_on   = main_q;
			r.assist_relay_on = assist_q;
			r.heat_request    = heat;
			r.over_limit      = lim_flag;
			case (duty)
				DUTY_RUN:  r.timer_phase = DUTY_CODE_RUN;
				DUTY_REST: r.timer_phase = DUTY_CODE_REST;
				default:   r.timer_phase = DUTY_CODE_IDLE;
			endcase
			r.timer_shown = shown;
			due_relays.push_back(r);
		endfunction

		function void compare_field(string name, int want, int got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_relays(hrs_result_t got);
			hrs_result_t want;
			if (due_relays.size() == 0) begin
				$error("relay result arrived with no scan outstanding");
				errors++;
			end else begin
				want = due_relays.pop_front();
				compare_field("main_relay_on", want.main_relay_on, got.main_relay_on);
				compare_field("assist_relay_on", want.assist_relay_on, got.assist_relay_on);
				compare_field("heat_request", want.heat_request, got.heat_request);
				compare_field("over_limit", want.over_limit, got.over_limit);
				compare_field("timer_phase", want.timer_phase, got.timer_phase);
				compare_field("timer_shown", want.timer_shown, got.timer_shown);
			end
		endfunction
	endclass

	relay_checker sb;

	heating_relay_supervisor_top dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.now_ms            (now_ms),
		.floor_demand      (floor_demand),
		.run_status        (run_status),
		.timing_display_on (timing_display_on),
		.system_error      (system_error),
		.floor_temp        (floor_temp),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.main_relay_on     (main_relay_on),
		.assist_relay_on   (assist_relay_on),
		.heat_request      (heat_request),
		.over_limit        (over_limit),
		.timer_phase       (timer_phase),
		.timer_shown       (timer_shown)
	);

	// 8 ns clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------
	function automatic hrs_item_t mk_scan(logic [15:0] t, logic demand, logic [1:0] rs,
		logic disp, logic err, int temp);
		hrs_item_t s;
		s.now_ms            = t;
		s.floor_demand      = demand;
		s.run_status        = rs;
		s.timing_display_on = disp;
		s.system_error      = err;
		s.floor_temp        = 11'(temp);
		return s;
	endfunction

	// mostly a steadily advancing clock with temperatures around the limit,
	// a little noise on time and temperature
	function automatic hrs_item_t random_scan(int limit);
		hrs_item_t s;
		int        pick;
		int        temp;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			scan_clock = scan_clock + 16'($urandom_range(0, 4000));
		else if (pick < 95)
			scan_clock = scan_clock + 16'($urandom_range(60000, 65535));
		else
			scan_clock = 16'($urandom);
		s.now_ms       = scan_clock;
		s.floor_demand = ($urandom_range(0, 99) < 80);
		pick = $urandom_range(0, 99);
		if (pick < 65)
			s.run_status = RS_NORMAL;
		else if (pick < 77)
			s.run_status = RS_POWER_OFF;
		else if (pick < 87)
			s.run_status = RS_HIGH_SET;
		else
			s.run_status = RS_TIMING;
		s.timing_display_on = 1'($urandom_range(0, 1));
		s.system_error      = ($urandom_range(0, 99) < 8);
		if ($urandom_range(0, 99) < 70) begin
			temp = limit - 45 + int'($urandom_range(0, 60));
			if (temp > 1023)
				temp = 1023;
			s.floor_temp = 11'(temp);
		end else begin
			s.floor_temp = 11'($urandom);
		end
		return s;
	endfunction

	function automatic hrs_cfg_t phase_settings(int p);
		hrs_cfg_t c;
		c.sensor_mode_all     = (p % 3 != 2);
		c.time_control_on     = (p % 5 != 4);
		c.relay_out_type      = 2'(p % 4);
		c.low_temp_protect_on = (p == 3) ? 1'b1 : 1'($urandom_range(0, 1));
		if (p == 2) begin
			c.run_minutes  = 8'd255;
			c.rest_minutes = 8'd255;
		end else if (p == 3) begin
			c.run_minutes  = 8'd0;
			c.rest_minutes = 8'd0;
		end else begin
			c.run_minutes  = 8'($urandom_range(0, 3));
			c.rest_minutes = 8'($urandom_range(0, 3));
		end
		case (p)
			4:       c.floor_limit_temp = 10'd0;
			5:       c.floor_limit_temp = 10'd1000;
			6:       c.floor_limit_temp = 10'd1023;
			default: c.floor_limit_temp = 10'($urandom_range(100, 600));
		endcase
		return c;
	endfunction

	// offer one scan and hold it until the transaction completes
	task automatic send_scan(hrs_item_t s);
		if (!steady) begin
			while ($urandom_range(0, 99) < 35) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid          <= 1'b1;
		now_ms            <= s.now_ms;
		floor_demand      <= s.floor_demand;
		run_status        <= s.run_status;
		timing_display_on <= s.timing_display_on;
		system_error      <= s.system_error;
		floor_temp        <= s.floor_temp;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.take_scan(s);
	endtask

	// stop offering until every outstanding result is back, then let the
	// two-register pipeline settle
	task automatic wait_results();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic apply_settings(hrs_cfg_t c);
		wait_results();
		write_reg(REG_SENSOR_MODE_ALL, CFG_DATA_W'(c.sensor_mode_all));
		write_reg(REG_FLOOR_LIMIT_TEMP, CFG_DATA_W'(c.floor_limit_temp));
		write_reg(REG_TIME_CONTROL_ON, CFG_DATA_W'(c.time_control_on));
		write_reg(REG_RUN_MINUTES, CFG_DATA_W'(c.run_minutes));
		write_reg(REG_REST_MINUTES, CFG_DATA_W'(c.rest_minutes));
		write_reg(REG_RELAY_OUT_TYPE, CFG_DATA_W'(c.relay_out_type));
		write_reg(REG_LOW_TEMP_PROTECT_ON, CFG_DATA_W'(c.low_temp_protect_on));
		cfg_we <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// result side: checks each transaction, random stall, two long hold-offs
	// ------------------------------------------------------------------------
	initial begin : result_sink
		int hold_left;
		int taken;
		hold_left = 0;
		taken     = 0;
		out_stall = 1'b1;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				sb.check_relays('{main_relay_on: main_relay_on,
					assist_relay_on: assist_relay_on, heat_request: heat_request,
					over_limit: over_limit, timer_phase: timer_phase,
					timer_shown: timer_shown});
				taken++;
				// hold results back so the block fills and stalls its input
				if (taken == 150 || taken == 520)
					hold_left = 150;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (steady) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 99) < 35);
			end
		end
	end

	// cycles with no transaction on either channel
	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_CYCLES) begin
				$display("heating_relay_supervisor_top: mismatch");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin : stimulus
		hrs_cfg_t c;
		sb                = new();
		steady            = 1'b0;
		scan_clock        = '0;
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = '0;
		cfg_data          = '0;
		in_valid          = 1'b0;
		now_ms            = '0;
		floor_demand      = 1'b0;
		run_status        = RS_NORMAL;
		timing_display_on = 1'b0;
		system_error      = 1'b0;
		floor_temp        = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: limit on, one-minute run, zero rest, inverted-off outputs
		c = '{sensor_mode_all: 1'b1, floor_limit_temp: 10'd350, time_control_on: 1'b1,
			run_minutes: 8'd1, rest_minutes: 8'd0, relay_out_type: OUT_INV_OFF,
			low_temp_protect_on: 1'b0};
		apply_settings(c);

		// start-up: first scan marks, exactly 3000 ms still waits, 3001 runs,
		// with the time wrapping across the delay
		send_scan(mk_scan(16'd65000, 1'b1, RS_NORMAL, 1'b0, 1'b0, 100));
		send_scan(mk_scan(16'd464, 1'b1, RS_NORMAL, 1'b0, 1'b0, 100));
		send_scan(mk_scan(16'd2464, 1'b1, RS_NORMAL, 1'b0, 1'b0, 100));
		send_scan(mk_scan(16'd2465, 1'b1, RS_NORMAL, 1'b0, 1'b0, 100));
		// duty timer starts, one minute flips to rest, zero rest flips back
		send_scan(mk_scan(16'd2500, 1'b1, RS_NORMAL, 1'b0, 1'b0, 100));
		send_scan(mk_scan(16'd62500, 1'b1, RS_NORMAL, 1'b0, 1'b0, 100));
		send_scan(mk_scan(16'd56964, 1'b1, RS_NORMAL, 1'b0, 1'b0, 100));
		// limit hysteresis: set at the limit, hold just above the low
		// threshold, clear on it
		send_scan(mk_scan(16'd57000, 1'b1, RS_NORMAL, 1'b0, 1'b0, 350));
		send_scan(mk_scan(16'd57100, 1'b1, RS_NORMAL, 1'b0, 1'b0, 321));
		send_scan(mk_scan(16'd57200, 1'b1, RS_NORMAL, 1'b0, 1'b0, 320));
		// temperature extremes, demand drop clears the limit
		send_scan(mk_scan(16'd57300, 1'b1, RS_NORMAL, 1'b0, 1'b0, 1023));
		send_scan(mk_scan(16'd57400, 1'b0, RS_NORMAL, 1'b0, 1'b0, 1023));
		send_scan(mk_scan(16'd57500, 1'b1, RS_NORMAL, 1'b0, 1'b0, -1024));
		// output enable cases: error while normal, timing set overrides an
		// error unless the display is on, high setting, powered off
		send_scan(mk_scan(16'd57600, 1'b1, RS_NORMAL, 1'b0, 1'b1, 100));
		send_scan(mk_scan(16'd57700, 1'b1, RS_TIMING, 1'b0, 1'b1, 400));
		send_scan(mk_scan(16'd57800, 1'b1, RS_TIMING, 1'b1, 1'b0, 100));
		send_scan(mk_scan(16'd57900, 1'b1, RS_HIGH_SET, 1'b0, 1'b0, 100));
		send_scan(mk_scan(16'd58000, 1'b1, RS_POWER_OFF, 1'b0, 1'b0, 100));
		send_scan(mk_scan(16'd58100, 1'b0, RS_POWER_OFF, 1'b1, 1'b1, 100));
		// time extremes
		send_scan(mk_scan(16'hFFFF, 1'b1, RS_NORMAL, 1'b0, 1'b0, 100));
		send_scan(mk_scan(16'h0000, 1'b1, RS_NORMAL, 1'b0, 1'b0, 100));
		scan_clock = 16'h0000;

		for (int p = 0; p < PHASES; p++) begin
			c = phase_settings(p);
			apply_settings(c);
			// one phase with no idling at all on either side
			steady = (p == 2);
			for (int n = 0; n < SCANS_PER_PHASE; n++) begin
				if (p == 5 && n == SCANS_PER_PHASE / 2)
					wait_results();
				send_scan(random_scan(int'(c.floor_limit_temp)));
			end
		end
		steady = 1'b0;

		wait_results();
		repeat (4) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("heating_relay_supervisor_top: match");
		else
			$display("heating_relay_supervisor_top: mismatch");
		$finish;
	end

endmodule
